### src/hpt_pkg.sv
// shared types and constants of the homogeneous point transform
// no dependencies
package hpt_pkg;

    localparam int CoordW = 32;           // Q16.16 coordinate
    localparam int CoefW  = 16;           // Q8.8 coefficient
    localparam int ProdW  = CoordW + CoefW;
    localparam int SumW   = 50;           // exact Q26.24 row sum
    localparam int MagW   = SumW - 1;     // magnitude of a row sum
    localparam int FracW  = 16;
    localparam int QuoW   = 32;           // quotient bits, one per cell
    localparam int Lanes  = 3;

    localparam logic [1:0] RegRow0 = 2'd0;
    localparam logic [1:0] RegRow1 = 2'd1;
    localparam logic [1:0] RegRow2 = 2'd2;
    localparam logic [1:0] RegRow3 = 2'd3;

    localparam logic [63:0] Row0Reset = 64'h0000_0000_0000_0100;
    localparam logic [63:0] Row1Reset = 64'h0000_0000_0100_0000;
    localparam logic [63:0] Row2Reset = 64'h0000_0100_0000_0000;
    localparam logic [63:0] Row3Reset = 64'h0100_0000_0000_0000;

    localparam logic [CoordW-1:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [CoordW-1:0] SatNeg = 32'h8000_0000;

    typedef struct packed {
        logic signed [CoordW-1:0] in_x;
        logic signed [CoordW-1:0] in_y;
        logic signed [CoordW-1:0] in_z;
    } in_word_t;

    typedef struct packed {
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic signed [CoordW-1:0] out_z;
        logic                     w_was_zero;
        logic                     saturated;
    } out_word_t;

    typedef struct packed {
        logic [MagW-1:0] rem;
        logic [QuoW-1:0] low;    // dividend bits shift out, quotient bits shift in
    } lane_t;

    typedef struct packed {
        lane_t [Lanes-1:0] lane;
        logic [MagW-1:0]   den;
        logic [Lanes-1:0]  neg;
        logic [Lanes-1:0]  ovf;
        logic [Lanes-1:0]  nzero;
        logic              wz;
    } div_word_t;

endpackage

### src/homogeneous_point_transform.sv
// top level: APB matrix registers, multiply front end, divider cell chain, output stage
// depends on hpt_pkg, hpt_mac, hpt_div_cell
//
// One point is accepted per clock while s_ready is high. Its word moves through the stages
// in order and is then loaded into the output register, which drives m_valid. The 36
// stages are: one of products, one of row sums, one of divider set-up, 32 cells of the
// divider chain (one quotient bit each) and the output register. The whole pipeline
// advances together whenever the output register is empty or being read, and s_ready is
// high exactly then. The four 64-bit matrix rows sit at byte addresses 0, 8, 16 and 24
// and should only be written while no point is in flight.
module homogeneous_point_transform (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  hpt_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output hpt_pkg::out_word_t m_word
);
    import hpt_pkg::*;

    logic [63:0] row_reg [4];
    logic        enable;
    logic        wr_en;
    logic        cv   [QuoW+1];
    div_word_t   cw   [QuoW+1];
    logic        out_valid_reg;
    out_word_t   out_reg, out_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign enable = !out_valid_reg || m_ready;
    assign s_ready = enable;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= Row0Reset;
            row_reg[1] <= Row1Reset;
            row_reg[2] <= Row2Reset;
            row_reg[3] <= Row3Reset;
        end else if (wr_en) begin
            case (paddr[4:3])
                RegRow0: row_reg[0] <= pwdata;
                RegRow1: row_reg[1] <= pwdata;
                RegRow2: row_reg[2] <= pwdata;
                RegRow3: row_reg[3] <= pwdata;
                default: row_reg[0] <= row_reg[0];
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            RegRow0: prdata = row_reg[0];
            RegRow1: prdata = row_reg[1];
            RegRow2: prdata = row_reg[2];
            RegRow3: prdata = row_reg[3];
            default: prdata = '0;
        endcase
    end

    hpt_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable),
        .row0      (row_reg[0]),
        .row1      (row_reg[1]),
        .row2      (row_reg[2]),
        .row3      (row_reg[3]),
        .in_valid  (s_valid),
        .in_word   (s_word),
        .out_valid (cv[0]),
        .out_word  (cw[0])
    );

    for (genvar k = 0; k < QuoW; k++) begin : g_cell
        hpt_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .enable    (enable),
            .in_valid  (cv[k]),
            .in_word   (cw[k]),
            .out_valid (cv[k+1]),
            .out_word  (cw[k+1])
        );
    end

    always_comb begin
        logic [CoordW-1:0] val [Lanes];
        logic [QuoW-1:0]   q;
        logic              sat;
        sat = 1'b0;
        for (int l = 0; l < Lanes; l++) begin
            q = cw[QuoW].lane[l].low;
            if (cw[QuoW].nzero[l]) begin
                val[l] = '0;
            end else if (cw[QuoW].wz || cw[QuoW].ovf[l]) begin
                // zero w lands here too, saturating by the numerator sign
                sat    = 1'b1;
                val[l] = cw[QuoW].neg[l] ? SatNeg : SatPos;
            end else if (cw[QuoW].neg[l]) begin
                if (q > SatNeg) begin
                    sat    = 1'b1;
                    val[l] = SatNeg;
                end else begin
                    val[l] = -q;
                end
            end else if (q[QuoW-1]) begin
                sat    = 1'b1;
                val[l] = SatPos;
            end else begin
                val[l] = q;
            end
        end
        out_next.out_x      = val[0];
        out_next.out_y      = val[1];
        out_next.out_z      = val[2];
        out_next.w_was_zero = cw[QuoW].wz;
        out_next.saturated  = sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (enable) begin
            out_valid_reg <= cv[QuoW];
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_zero_w_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.w_was_zero && !m_word.saturated |->
            m_word.out_x == 0 && m_word.out_y == 0 && m_word.out_z == 0)
        else $error("zero w without saturation gave a nonzero coordinate");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> u_mac.v1_reg)
        else $error("accepted word did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !enable |=> $stable(cv[QuoW]) && $stable(cv[0]))
        else $error("pipeline moved during a stall");

endmodule

### src/hpt_mac.sv
// matrix multiply front end: products, row sums, divider set-up
// depends on hpt_pkg
module hpt_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic [63:0]       row0,
    input  logic [63:0]       row1,
    input  logic [63:0]       row2,
    input  logic [63:0]       row3,
    input  logic              in_valid,
    input  hpt_pkg::in_word_t in_word,
    output logic              out_valid,
    output hpt_pkg::div_word_t out_word
);
    import hpt_pkg::*;

    logic signed [ProdW-1:0] prod_reg  [4][3];
    logic signed [ProdW-1:0] prod_next [4][3];
    logic signed [CoefW-1:0] c3_reg  [4];
    logic signed [SumW-1:0]  sum_reg  [4];
    logic signed [SumW-1:0]  sum_next [4];
    div_word_t               prep_reg, prep_next;
    logic                    v1_reg, v2_reg, v3_reg;
    logic [63:0]             rows [4];
    logic signed [CoordW-1:0] xs [3];

    assign rows[0] = row0;
    assign rows[1] = row1;
    assign rows[2] = row2;
    assign rows[3] = row3;
    assign xs[0] = in_word.in_x;
    assign xs[1] = in_word.in_y;
    assign xs[2] = in_word.in_z;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = $signed(rows[i][16*j +: 16]) * xs[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum_next[i] = SumW'(prod_reg[i][0]) + SumW'(prod_reg[i][1])
                        + SumW'(prod_reg[i][2])
                        + (SumW'(c3_reg[i]) <<< FracW);
        end
    end

    always_comb begin
        logic [MagW-1:0] d;
        logic [MagW-1:0] n;
        d = sum_reg[3][SumW-1] ? MagW'(-sum_reg[3]) : MagW'(sum_reg[3]);
        prep_next.den = d;
        prep_next.wz  = (sum_reg[3] == '0);
        for (int l = 0; l < Lanes; l++) begin
            n = sum_reg[l][SumW-1] ? MagW'(-sum_reg[l]) : MagW'(sum_reg[l]);
            prep_next.neg[l]   = sum_reg[l][SumW-1] ^ sum_reg[3][SumW-1];
            prep_next.nzero[l] = (sum_reg[l] == '0);
            // integer part of the quotient would not fit in 16 bits
            prep_next.ovf[l]   = {16'b0, n} >= {d, 16'b0};
            prep_next.lane[l].rem = {16'b0, n[MagW-1:FracW]};
            prep_next.lane[l].low = {n[FracW-1:0], 16'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (enable) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= prod_next[i][j];
                end
                c3_reg[i]  <= $signed(rows[i][63:48]);
                sum_reg[i] <= sum_next[i];
            end
            prep_reg <= prep_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_word  = prep_reg;

endmodule

### src/hpt_div_cell.sv
// one restoring-division cell: one quotient bit for each of the three lanes
// depends on hpt_pkg
module hpt_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               enable,
    input  logic               in_valid,
    input  hpt_pkg::div_word_t in_word,
    output logic               out_valid,
    output hpt_pkg::div_word_t out_word
);
    import hpt_pkg::*;

    logic      valid_reg;
    div_word_t word_reg, word_next;

    always_comb begin
        logic [MagW:0] r2;
        logic          bit_q;
        word_next = in_word;
        for (int l = 0; l < Lanes; l++) begin
            r2    = {in_word.lane[l].rem, in_word.lane[l].low[QuoW-1]};
            bit_q = (r2 >= {1'b0, in_word.den});
            word_next.lane[l].rem = bit_q ? MagW'(r2 - {1'b0, in_word.den})
                                          : r2[MagW-1:0];
            word_next.lane[l].low = {in_word.lane[l].low[QuoW-2:0], bit_q};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### tb/tb_top.sv
// self-checking bench for the homogeneous point transform: matrix rows via APB,
// points in, projected points checked against a local predictor; depends on hpt_pkg and homogeneous_point_transform
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hpt_pkg::*;

    localparam int Latency = 37;
    localparam int CycleLimit = 400000;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [63:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    in_word_t s_word;
    logic m_valid, m_ready;
    out_word_t m_word;

    homogeneous_point_transform uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    logic [63:0] rows [4];
    in_word_t pending_points [$];
    out_word_t projected [$];
    int mismatches;
    int cycles;
    int send_gap;
    int stall_len;
    bit hold_send;
    bit lazy_send;
    bit lazy_recv;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) cycles <= cycles + 1;

    initial begin
        cycles = 0;
    end

    always @(posedge aclk) begin
        if (cycles > CycleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic signed [49:0] row_dot(logic [63:0] row, in_word_t p);
        logic signed [49:0] acc;
        acc = $signed(row[15:0]) * $signed({{18{p.in_x[31]}}, p.in_x});
        acc += $signed(row[31:16]) * $signed({{18{p.in_y[31]}}, p.in_y});
        acc += $signed(row[47:32]) * $signed({{18{p.in_z[31]}}, p.in_z});
        acc += $signed(row[63:48]) * 50'sd65536;
        return acc;
    endfunction

    function automatic logic [31:0] project_lane(logic signed [49:0] num,
                                                 logic signed [49:0] w, inout bit sat);
        logic [63:0] n, d, q;
        bit neg;
        if (num == 0) return 32'd0;
        if (w == 0) begin
            sat = 1;
            return num > 0 ? SatPos : SatNeg;
        end
        neg = (num < 0) != (w < 0);
        n = num < 0 ? -64'(num) : 64'(num);
        d = w < 0 ? -64'(w) : 64'(w);
        if (n / d >= 64'h10000) begin
            sat = 1;
            return neg ? SatNeg : SatPos;
        end
        q = (n << 16) / d;
        if (neg) begin
            if (q > 64'h8000_0000) begin
                sat = 1;
                q = 64'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            sat = 1;
            q = 64'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic out_word_t transform_point(in_word_t p);
        out_word_t r;
        logic signed [49:0] w;
        bit sat;
        sat = 0;
        w = row_dot(rows[3], p);
        r.out_x = project_lane(row_dot(rows[0], p), w, sat);
        r.out_y = project_lane(row_dot(rows[1], p), w, sat);
        r.out_z = project_lane(row_dot(rows[2], p), w, sat);
        r.w_was_zero = (w == 0);
        r.saturated = sat;
        return r;
    endfunction

    // driver: one word per handshake, random gaps, optional hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && !s_ready) begin
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (!hold_send && pending_points.size() > 0) begin
            s_word <= pending_points[0];
            projected.push_back(transform_point(pending_points.pop_front()));
            s_valid <= 1'b1;
            if (lazy_send)
                send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 3);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // monitor: check each accepted word against the oldest expectation, random stalls on m_ready
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_len <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (projected.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected word %h", m_word);
                end else begin
                    want = projected.pop_front();
                    if (m_word !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp %h %h %h z%b s%b got %h %h %h z%b s%b",
                                     want.out_x, want.out_y, want.out_z, want.w_was_zero,
                                     want.saturated, m_word.out_x, m_word.out_y,
                                     m_word.out_z, m_word.w_was_zero, m_word.saturated);
                    end
                end
            end
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                stall_len <= stall_len - 1;
            end else if (lazy_recv && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                stall_len <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_row(logic [1:0] idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rows[idx] = val;
        // idle cycle so back-to-back writes never overlap
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || projected.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (Latency + 5) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
            3: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'd0;
            default: return 32'($signed($urandom_range(0, 40)) - 20) << 16;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 1024)) - 512);
            2: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
            3: return 16'd0;
            default: return 16'h0100;
        endcase
    endfunction

    task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_word_t p;
        p.in_x = x;
        p.in_y = y;
        p.in_z = z;
        pending_points.push_back(p);
    endtask

    initial begin
        logic [63:0] r;
        rows[0] = Row0Reset;
        rows[1] = Row1Reset;
        rows[2] = Row2Reset;
        rows[3] = Row3Reset;
        mismatches = 0;
        hold_send = 0;
        lazy_send = 0;
        lazy_recv = 0;
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_word = '0; m_ready = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, extremes, zero numerator
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
        push_point(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();
        // w from x: zero w, small w, negative w
        write_row(RegRow3, {16'h0000, 16'h0000, 16'h0000, 16'h0100});
        push_point(32'h0, 32'h0001_0000, 32'hFFFF_0000);
        push_point(32'h0, 32'h0, 32'h0);
        push_point(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        push_point(32'hFFFF_FFFF, 32'h0003_0000, 32'h0);
        push_point(32'h0002_0000, 32'h0003_0000, 32'hFFFD_0000);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        drain();
        // extreme coefficients in rows 0 to 2
        write_row(RegRow0, 64'h7FFF_7FFF_7FFF_7FFF);
        write_row(RegRow1, 64'h8000_8000_8000_8000);
        write_row(RegRow2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_row(RegRow3, 64'h0001_0000_0000_0000);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'h0, 32'h0, 32'h0);
        drain();
        write_row(RegRow3, 64'h8000_7FFF_8000_7FFF);
        push_point(32'h0000_0001, 32'h0, 32'h0000_0001);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        drain();
        write_row(RegRow3, 64'h0000_0000_0000_0000);
        push_point(32'h0001_0000, 32'h0, 32'h0);
        drain();

        // random phases, new matrix each time
        lazy_send = 1;
        lazy_recv = 1;
        for (int ph = 0; ph < 12; ph++) begin
            for (int i = 0; i < 4; i++) begin
                r = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
                if (i == 3 && $urandom_range(0, 2) == 0) r[63:48] = 16'h0100;
                write_row(i[1:0], r);
            end
            lazy_send = (ph % 4) != 3;
            lazy_recv = (ph % 4) != 2;
            for (int i = 0; i < 50; i++)
                push_point(rand_coord(), rand_coord(), rand_coord());
            if (ph == 5) begin
                // let the pipe empty before sending on
                while (pending_points.size() > 25) @(posedge aclk);
                hold_send = 1;
                while (projected.size() > 0) @(posedge aclk);
                hold_send = 0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

### files.f
src/hpt_pkg.sv
src/hpt_mac.sv
src/hpt_div_cell.sv
src/homogeneous_point_transform.sv
tb/tb_top.sv
